[design/iapd_pkg.sv]
// ----------------------------------------------------------------------------
// iapd_pkg
// Types and constants shared by the IMU angle packet deframer files.
// ----------------------------------------------------------------------------
package iapd_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'h55;
  localparam logic [7:0] HDR_SECOND = 8'h53;
  localparam logic [7:0] HDR_SUM    = HDR_FIRST + HDR_SECOND;

  localparam int unsigned DATA_BYTES = 8;
  localparam int unsigned ADDR_W     = $clog2(DATA_BYTES);
  localparam int unsigned POS_W      = 4;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(DATA_BYTES);

  typedef enum logic [1:0] {
    PH_WAIT1 = 2'd0,
    PH_WAIT2 = 2'd1,
    PH_DATA  = 2'd2
  } phase_t;

endpackage

[design/iapd_in_if.sv]
// ----------------------------------------------------------------------------
// iapd_in_if
// Byte channel into the deframer: one received serial byte per item.
// ----------------------------------------------------------------------------
interface iapd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[design/iapd_out_if.sv]
// ----------------------------------------------------------------------------
// iapd_out_if
// Result channel of the deframer: one decoded angle packet per item.
// ----------------------------------------------------------------------------
interface iapd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  logic        [15:0] extra_word;
  logic               checksum_ok;

  modport source (output valid, output roll_angle, output pitch_angle,
                  output yaw_angle, output extra_word, output checksum_ok,
                  input ready);
  modport sink   (input valid, input roll_angle, input pitch_angle,
                  input yaw_angle, input extra_word, input checksum_ok,
                  output ready);
endinterface

[design/imu_angle_packet_deframer.sv]
// ----------------------------------------------------------------------------
// imu_angle_packet_deframer
// Deframes 0x55 0x53 angle packets from a serial byte stream and emits
// roll, pitch, yaw, the fourth word and a checksum flag per packet.
// ----------------------------------------------------------------------------
// channel   port     direction  payload
// input     in_if    sink       rx_byte[7:0]
// result    out_if   source     roll/pitch/yaw_angle, extra_word, checksum_ok
//
// One byte per cycle while in_if.ready is high. A byte is parsed in the cycle it is taken;
// the result of a checksum byte shows on out_if in the cycle after.
// in_if.ready drops only while a result sits in the output register and
// out_if.ready is low. rst_n is synchronous, active low; no clearing pass.
// ----------------------------------------------------------------------------
module imu_angle_packet_deframer (
  input  logic       clk,
  input  logic       rst_n,
  iapd_in_if.sink    in_if,
  iapd_out_if.source out_if
);

  iapd_pkg::phase_t                 phase_r, phase_nxt;
  logic [iapd_pkg::POS_W-1:0]       pos_r, pos_nxt;
  logic [7:0]                       sum_r, sum_nxt;
  logic [7:0]                       store_r [iapd_pkg::DATA_BYTES];

  logic                             in_acc;
  logic                             store_we;
  logic                             emit;
  logic                             out_valid_r;
  logic signed [15:0]               roll_r, pitch_r, yaw_r;
  logic [15:0]                      extra_r;
  logic                             ok_r;
  logic [7:0]                       b;

  assign b           = in_if.rx_byte;
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_acc      = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= iapd_pkg::PH_WAIT1;
      pos_r   <= '0;
      sum_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    store_we  = 1'b0;
    emit      = 1'b0;
    if (in_acc) begin
      case (phase_r)
        iapd_pkg::PH_WAIT2: begin
          if (b == iapd_pkg::HDR_SECOND) begin
            phase_nxt = iapd_pkg::PH_DATA;
            pos_nxt   = '0;
            sum_nxt   = iapd_pkg::HDR_SUM;
          end else begin
            phase_nxt = iapd_pkg::PH_WAIT1;
          end
        end
        iapd_pkg::PH_DATA: begin
          if (pos_r < iapd_pkg::POS_LAST) begin
            store_we = 1'b1;
            sum_nxt  = sum_r + b;
            pos_nxt  = pos_r + 1'b1;
          end else begin
            emit      = (pos_r == iapd_pkg::POS_LAST);
            phase_nxt = iapd_pkg::PH_WAIT1;
            pos_nxt   = '0;
          end
        end
        default: begin
          phase_nxt = (b == iapd_pkg::HDR_FIRST) ? iapd_pkg::PH_WAIT2
                                                 : iapd_pkg::PH_WAIT1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[pos_r[iapd_pkg::ADDR_W-1:0]] <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      roll_r  <= $signed({store_r[1], store_r[0]});
      pitch_r <= $signed({store_r[3], store_r[2]});
      yaw_r   <= $signed({store_r[5], store_r[4]});
      extra_r <= {store_r[7], store_r[6]};
      ok_r    <= (sum_r == b);
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.roll_angle  = roll_r;
  assign out_if.pitch_angle = pitch_r;
  assign out_if.yaw_angle   = yaw_r;
  assign out_if.extra_word  = extra_r;
  assign out_if.checksum_ok = ok_r;

endmodule

[design/iapd_checker.sv]
// ----------------------------------------------------------------------------
// iapd_checker
// Port-level checks on the IMU angle packet deframer, bound to the top level.
// ----------------------------------------------------------------------------
module iapd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_roll,
  input logic [15:0] out_pitch,
  input logic [15:0] out_yaw,
  input logic [15:0] out_extra,
  input logic        out_ok
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable({out_roll, out_pitch, out_yaw, out_extra, out_ok}))
    else $error("stalled result item changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_new_from_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result item without an accepted byte");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

endmodule

bind imu_angle_packet_deframer iapd_checker u_iapd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_roll  (out_if.roll_angle),
  .out_pitch (out_if.pitch_angle),
  .out_yaw   (out_if.yaw_angle),
  .out_extra (out_if.extra_word),
  .out_ok    (out_if.checksum_ok)
);

[tb/sv/iapd_deframer_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iapd_deframer_checker
// Watches the byte and result channels of the angle packet deframer. Every
// accepted byte runs through an independent parser model. Each packet it
// completes queues an expected result, and every accepted result is compared
// field by field against the oldest one queued.
// ----------------------------------------------------------------------------
module iapd_deframer_checker (
  input  logic clk,
  input  logic rst_n,
  iapd_in_if   in_ch,
  iapd_out_if  out_ch,
  output int   err_count,
  output int   pending
);

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic        [15:0] extra;
    logic               cs_ok;
  } angle_rec_t;

  angle_rec_t                 angle_q [$];
  iapd_pkg::phase_t           phase;
  logic [iapd_pkg::POS_W-1:0] pos;
  logic [7:0]                 data_buf [iapd_pkg::DATA_BYTES];
  logic [7:0]                 byte_sum;

  initial begin
    err_count = 0;
    pending   = 0;
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    angle_rec_t rec;
    case (phase)
      iapd_pkg::PH_WAIT2: begin
        if (b == iapd_pkg::HDR_SECOND) begin
          phase    = iapd_pkg::PH_DATA;
          pos      = '0;
          byte_sum = iapd_pkg::HDR_SUM;
        end else begin
          phase = iapd_pkg::PH_WAIT1;
        end
      end
      iapd_pkg::PH_DATA: begin
        if (pos < iapd_pkg::POS_LAST) begin
          data_buf[pos[iapd_pkg::ADDR_W-1:0]] = b;
          byte_sum = byte_sum + b;
          pos      = pos + 1'b1;
        end else begin
          if (pos == iapd_pkg::POS_LAST) begin
            rec.roll  = {data_buf[1], data_buf[0]};
            rec.pitch = {data_buf[3], data_buf[2]};
            rec.yaw   = {data_buf[5], data_buf[4]};
            rec.extra = {data_buf[7], data_buf[6]};
            rec.cs_ok = (byte_sum == b);
            angle_q.push_back(rec);
          end
          phase = iapd_pkg::PH_WAIT1;
          pos   = '0;
        end
      end
      default: begin
        phase = (b == iapd_pkg::HDR_FIRST) ? iapd_pkg::PH_WAIT2 : iapd_pkg::PH_WAIT1;
      end
    endcase
  endtask

  task automatic check_result();
    angle_rec_t want;
    if (angle_q.size() == 0) begin
      report_mismatch("result with nothing expected", out_ch.roll_angle, 16'h0);
    end else begin
      want = angle_q.pop_front();
      if (out_ch.roll_angle !== want.roll)
        report_mismatch("roll_angle", out_ch.roll_angle, want.roll);
      if (out_ch.pitch_angle !== want.pitch)
        report_mismatch("pitch_angle", out_ch.pitch_angle, want.pitch);
      if (out_ch.yaw_angle !== want.yaw)
        report_mismatch("yaw_angle", out_ch.yaw_angle, want.yaw);
      if (out_ch.extra_word !== want.extra)
        report_mismatch("extra_word", out_ch.extra_word, want.extra);
      if (out_ch.checksum_ok !== want.cs_ok)
        report_mismatch("checksum_ok", 16'(out_ch.checksum_ok), 16'(want.cs_ok));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase    = iapd_pkg::PH_WAIT1;
      pos      = '0;
      byte_sum = '0;
      angle_q.delete();
    end else begin
      // a result taken now stems from an earlier byte, so check it first
      if (out_ch.valid && out_ch.ready) check_result();
      if (in_ch.valid && in_ch.ready) parse_byte(in_ch.rx_byte);
    end
    pending <= angle_q.size();
  end

endmodule

[tb/sv/tb_imu_angle_packet_deframer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_imu_angle_packet_deframer
// Feeds the deframer directed and random byte streams: well-formed packets
// with random content and good or bad checksums, mixed with noise and broken
// headers. Both channels idle in random bursts, and the result side holds off
// once for a long stretch. The checker judges the results.
// ----------------------------------------------------------------------------
module tb_imu_angle_packet_deframer;

  localparam int N_ITEMS     = 1400;
  localparam int QUIET_AT    = N_ITEMS - 200;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN       = 8;
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst_n;
  int   err_count;
  int   results_left;
  int   sent;
  int   progress;
  logic quiet;
  int   cycles;

  iapd_in_if  in_ch ();
  iapd_out_if out_ch ();

  imu_angle_packet_deframer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  iapd_deframer_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .err_count (err_count),
    .pending   (results_left)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // result side: random stall bursts plus one long hold-off
  initial begin
    int stall;
    int hold_left;
    bit hold_done;
    stall     = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && progress >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 18) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 18);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    progress <= sent;
    if (sent >= QUIET_AT) quiet <= 1'b1;
  endtask

  task automatic send_packet(input logic [15:0] w0, input logic [15:0] w1,
                             input logic [15:0] w2, input logic [15:0] w3,
                             input bit good);
    logic [7:0] d [8];
    logic [7:0] cs;
    {d[1], d[0]} = w0;
    {d[3], d[2]} = w1;
    {d[5], d[4]} = w2;
    {d[7], d[6]} = w3;
    cs = iapd_pkg::HDR_SUM;
    foreach (d[i]) cs = cs + d[i];
    if (!good) cs = cs + 8'($urandom_range(1, 255));
    send_byte(iapd_pkg::HDR_FIRST);
    send_byte(iapd_pkg::HDR_SECOND);
    foreach (d[i]) send_byte(d[i]);
    send_byte(cs);
  endtask

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 5))
      0:       return iapd_pkg::HDR_FIRST;
      1:       return iapd_pkg::HDR_SECOND;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    int sel;
    int n;
    logic [7:0] b;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready  = 1'b0;
    sent          = 0;
    progress      = 0;
    quiet         = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // 0x55 as second header must not resync
    send_byte(iapd_pkg::HDR_FIRST);
    send_byte(iapd_pkg::HDR_FIRST);
    send_byte(iapd_pkg::HDR_SECOND);
    send_packet(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 1'b1);
    // header bytes inside payload, bad checksum
    send_packet(16'h5555, 16'h5355, 16'h0180, 16'hFE7F, 1'b0);

    while (sent < N_ITEMS) begin
      sel = $urandom_range(0, 19);
      if (sel < 14) begin
        send_packet(rand_word(), rand_word(), rand_word(), rand_word(),
                    $urandom_range(0, 3) != 0);
      end else if (sel < 16) begin
        n = $urandom_range(1, 6);
        repeat (n) send_byte(noise_byte());
      end else if (sel == 16) begin
        b = 8'($urandom);
        if (b == iapd_pkg::HDR_SECOND) b = ~b;
        send_byte(iapd_pkg::HDR_FIRST);
        send_byte(b);
      end else if (sel == 17) begin
        send_byte(iapd_pkg::HDR_FIRST);
        send_byte(iapd_pkg::HDR_FIRST);
        send_byte(iapd_pkg::HDR_SECOND);
      end else if (sel == 18) begin
        // truncated packet: the next bytes finish it
        n = $urandom_range(1, 8);
        send_byte(iapd_pkg::HDR_FIRST);
        send_byte(iapd_pkg::HDR_SECOND);
        repeat (n) send_byte(8'($urandom));
      end else begin
        send_byte(iapd_pkg::HDR_SECOND);
      end
    end
    in_ch.valid <= 1'b0;

    // let the count of the last accepted byte settle
    @(posedge clk);
    while (results_left != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
design/iapd_pkg.sv
design/iapd_in_if.sv
design/iapd_out_if.sv
design/imu_angle_packet_deframer.sv
design/iapd_checker.sv
tb/sv/iapd_deframer_checker.sv
tb/sv/tb_imu_angle_packet_deframer.sv
